// File: sv/multilevel_ready_queue_defines.svh
// Assertion macros for the multilevel ready queue.
// Depends on the clock clk and the reset arst_n of the module that includes it.
`ifndef MULTILEVEL_READY_QUEUE_DEFINES_SVH
`define MULTILEVEL_READY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define MRQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define MRQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/mrq_pkg.sv
// Package for the multilevel ready queue: transaction payload structs,
// operation and status codes, controller state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrq_pkg;

	// operation codes
	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic       func;
		logic [7:0] task_id;
		logic [2:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [7:0] out_task_id;
		logic [1:0] status;
		logic [2:0] top_priority;
		logic       none_ready;
	} rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

`default_nettype wire

// File: sv/multilevel_ready_queue.sv
// Multilevel ready queue: one task-id FIFO per priority level in a shared store.
// Depends on mrq_pkg and multilevel_ready_queue_defines.svh.
//
//   channel | handshake            | dir | payload fields
//   --------+----------------------+-----+-----------------------------------------------
//   req     | req_valid, req_ready | in  | func, task_id, priority_req
//   rsp     | rsp_valid, rsp_ready | out | out_task_id, status, top_priority, none_ready
//
// Each transaction has an accept cycle, which reads the level's head slot from the store
// (synchronous read), and an execute cycle, which updates that level's pointers and count,
// writes the store on enqueue, loads the result register; no request is taken meanwhile.
// Reset clears every level's head, tail and count; the store itself is never cleared.
// A stalled result holds in the output register; the next request is taken only once that
// register is free or is being drained in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "multilevel_ready_queue_defines.svh"

module multilevel_ready_queue #(
	parameter int NUM_LEVELS  = 8,
	parameter int LEVEL_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire mrq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output mrq_pkg::rsp_t      rsp
);

	localparam int LW      = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int PW      = $clog2(LEVEL_DEPTH);
	localparam int CW      = $clog2(LEVEL_DEPTH + 1);
	localparam int ENTRIES = NUM_LEVELS * LEVEL_DEPTH;
	localparam int AW      = $clog2(ENTRIES);
	localparam int WB      = (ID_BITS > 8) ? ID_BITS : 8;

	// controller
	mrq_pkg::state_t state_q, state_d;
	logic            accept;
	logic            exec;
	logic            take_ok;

	// captured request
	mrq_pkg::req_t op_q;

	// per-level bookkeeping
	logic [PW-1:0] head_q  [NUM_LEVELS];
	logic [PW-1:0] tail_q  [NUM_LEVELS];
	logic [CW-1:0] count_q [NUM_LEVELS];

	// task-id store, one region of LEVEL_DEPTH slots per level
	logic [ID_BITS-1:0] store_mem [ENTRIES];
	logic [ID_BITS-1:0] rdata_q;

	// result register
	mrq_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;

	// read side (accept cycle)
	logic          in_range_in;
	logic [LW-1:0] lvl_in;
	logic [AW-1:0] rd_addr;

	// execute side
	logic               in_range_q;
	logic [LW-1:0]      lvl_q;
	logic [PW-1:0]      head_sel;
	logic [PW-1:0]      tail_sel;
	logic [CW-1:0]      cnt_sel;
	logic [PW-1:0]      head_nxt;
	logic [PW-1:0]      tail_nxt;
	logic [CW-1:0]      cnt_nxt;
	logic               is_enq;
	logic               enq_ok;
	logic               deq_ok;
	logic [AW-1:0]      wr_addr;
	logic [WB-1:0]      id_wide;
	logic [WB-1:0]      rd_wide;
	logic [ID_BITS-1:0] wr_data;
	logic [NUM_LEVELS-1:0] nonempty_nxt;
	logic [LW-1:0]      top_idx;
	logic               any_ready;
	mrq_pkg::rsp_t      rsp_d;

	// ------------------------------------------------------------------
	// Controller: take a request only when the result register will be free
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		take_ok = 1'b0;
		exec    = 1'b0;
		unique case (state_q)
			mrq_pkg::ST_IDLE: begin
				take_ok = !rsp_valid_q || rsp_ready;
				if (req_valid && take_ok) begin
					state_d = mrq_pkg::ST_EXEC;
				end
			end
			mrq_pkg::ST_EXEC: begin
				exec    = 1'b1;
				state_d = mrq_pkg::ST_IDLE;
			end
		endcase
	end

	assign req_ready = take_ok;
	assign accept    = req_valid && take_ok;

	// Hold the request for the execute cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req;
		end
	end

	// ------------------------------------------------------------------
	// Accept cycle: address the head slot of the requested level
	// ------------------------------------------------------------------
	assign in_range_in = 32'(req.priority_req) < 32'(NUM_LEVELS);
	assign lvl_in      = in_range_in ? LW'(req.priority_req) : '0;
	assign rd_addr     = AW'(32'(lvl_in) * 32'(LEVEL_DEPTH) + 32'(head_q[lvl_in]));

	// ------------------------------------------------------------------
	// Execute cycle: decide the outcome, advance pointers, build the result
	// ------------------------------------------------------------------
	assign in_range_q = 32'(op_q.priority_req) < 32'(NUM_LEVELS);
	assign lvl_q      = in_range_q ? LW'(op_q.priority_req) : '0;
	assign head_sel   = head_q[lvl_q];
	assign tail_sel   = tail_q[lvl_q];
	assign cnt_sel    = count_q[lvl_q];

	assign is_enq = (op_q.func == mrq_pkg::FUNC_ENQ);
	// An out-of-range level has no FIFO: treat it as full on enqueue, empty on dequeue.
	assign enq_ok = is_enq && in_range_q && (cnt_sel != CW'(LEVEL_DEPTH));
	assign deq_ok = !is_enq && in_range_q && (cnt_sel != '0);

	// Wrap pointers at the level depth, which need not be a power of two.
	assign head_nxt = (head_sel == PW'(LEVEL_DEPTH - 1)) ? '0 : head_sel + PW'(1);
	assign tail_nxt = (tail_sel == PW'(LEVEL_DEPTH - 1)) ? '0 : tail_sel + PW'(1);

	always_comb begin
		cnt_nxt = cnt_sel;
		priority if (enq_ok) begin
			cnt_nxt = cnt_sel + CW'(1);
		end else if (deq_ok) begin
			cnt_nxt = cnt_sel - CW'(1);
		end
	end

	assign wr_addr = AW'(32'(lvl_q) * 32'(LEVEL_DEPTH) + 32'(tail_sel));

	// Keep the low ID_BITS of the task id; widen or trim through a common width.
	assign id_wide = WB'(op_q.task_id);
	assign wr_data = id_wide[ID_BITS-1:0];
	assign rd_wide = WB'(rdata_q);

	// Occupancy after this transaction, then pick the most urgent busy level.
	always_comb begin
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (in_range_q && (LW'(i) == lvl_q)) begin
				nonempty_nxt[i] = (cnt_nxt != '0);
			end else begin
				nonempty_nxt[i] = (count_q[i] != '0);
			end
		end
	end

	always_comb begin
		top_idx = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (nonempty_nxt[i]) begin
				top_idx = LW'(i);
			end
		end
	end

	assign any_ready = |nonempty_nxt;

	always_comb begin
		rsp_d.out_task_id  = deq_ok ? rd_wide[7:0] : 8'd0;
		rsp_d.top_priority = any_ready ? 3'(top_idx) : 3'd0;
		rsp_d.none_ready   = !any_ready;
		priority if (is_enq && !enq_ok) begin
			rsp_d.status = mrq_pkg::STAT_FULL;
		end else if (!is_enq && !deq_ok) begin
			rsp_d.status = mrq_pkg::STAT_EMPTY;
		end else begin
			rsp_d.status = mrq_pkg::STAT_OK;
		end
	end

	// ------------------------------------------------------------------
	// Task-id store: write on a successful enqueue, read at accept
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (exec && enq_ok) begin
			store_mem[wr_addr] <= wr_data;
		end
		if (accept) begin
			rdata_q <= store_mem[rd_addr];
		end
	end

	// ------------------------------------------------------------------
	// Per-level pointers and counts
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (exec) begin
			if (enq_ok) begin
				tail_q[lvl_q] <= tail_nxt;
			end
			if (deq_ok) begin
				head_q[lvl_q] <= head_nxt;
			end
			if (enq_ok || deq_ok) begin
				count_q[lvl_q] <= cnt_nxt;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register: load on execute, drop once the consumer takes it
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (exec) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`MRQ_ASSERT_NEXT(a_accept_to_exec, accept, exec, "no execute after accept")
	`MRQ_ASSERT_NOW(a_exec_out_free, exec, !rsp_valid_q, "result register busy in execute")
	`MRQ_ASSERT_NEXT(a_exec_gives_rsp, exec, rsp_valid_q, "execute produced no result")
	`MRQ_ASSERT_NOW(a_count_bound, exec, cnt_sel <= CW'(LEVEL_DEPTH), "count over depth")

endmodule

`default_nettype wire

// File: verif/tb_multilevel_ready_queue.sv
// Testbench for the multilevel ready queue: shadow FIFOs per level predict every result.
// Depends on mrq_pkg and the multilevel_ready_queue RTL.
`timescale 1ns / 1ps

// Shadow copy of the per-level FIFOs; predicts each result and checks it on arrival.
class ready_queue_scoreboard #(int LEVELS = 8, int DEPTH = 16, int ID_W = 8);
	localparam logic [7:0] ID_MASK = 8'((1 << ID_W) - 1);

	logic [7:0]     level_ids [LEVELS][DEPTH];
	int             head_slot [LEVELS];
	int             tail_slot [LEVELS];
	int             level_fill [LEVELS];
	mrq_pkg::rsp_t  results_due [$];
	int             mismatches;

	// Advance the shadow state by one accepted request and queue its result.
	function void apply_request(mrq_pkg::req_t item);
		mrq_pkg::rsp_t want;
		int lvl;
		want = '0;
		want.status = mrq_pkg::STAT_OK;
		lvl = int'(item.priority_req);
		if (item.func == mrq_pkg::FUNC_ENQ) begin
			if (lvl >= LEVELS || level_fill[lvl] >= DEPTH) begin
				want.status = mrq_pkg::STAT_FULL;
			end else begin
				level_ids[lvl][tail_slot[lvl]] = item.task_id & ID_MASK;
				tail_slot[lvl] = (tail_slot[lvl] + 1) % DEPTH;
				level_fill[lvl]++;
			end
		end else begin
			if (lvl >= LEVELS || level_fill[lvl] == 0) begin
				want.status = mrq_pkg::STAT_EMPTY;
			end else begin
				want.out_task_id = level_ids[lvl][head_slot[lvl]];
				head_slot[lvl] = (head_slot[lvl] + 1) % DEPTH;
				level_fill[lvl]--;
			end
		end
		// scan from the least urgent level so the most urgent non-empty one wins
		want.none_ready = 1'b1;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (level_fill[i] != 0) begin
				want.top_priority = 3'(i);
				want.none_ready = 1'b0;
			end
		end
		results_due.push_back(want);
	endfunction

	function void compare_field(string field, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endfunction

	// Compare one delivered result with the oldest prediction.
	function void check_result(mrq_pkg::rsp_t got);
		mrq_pkg::rsp_t want;
		if (results_due.size() == 0) begin
			mismatches++;
			$display("%0t: result with nothing outstanding, expected none, actual %p",
				$time, got);
			return;
		end
		want = results_due.pop_front();
		compare_field("out_task_id", want.out_task_id, got.out_task_id);
		compare_field("status", 8'(want.status), 8'(got.status));
		compare_field("top_priority", 8'(want.top_priority), 8'(got.top_priority));
		compare_field("none_ready", 8'(want.none_ready), 8'(got.none_ready));
	endfunction

	function int pending();
		return results_due.size();
	endfunction
endclass

module tb_multilevel_ready_queue;

	localparam int NUM_LEVELS     = 8;
	localparam int LEVEL_DEPTH    = 16;
	localparam int ID_BITS        = 8;
	localparam int RANDOM_ITEMS   = 530;
	localparam int QUIET_ITEMS    = 80;   // final stretch with no idling on either side
	localparam int HOLD_AT        = 150;  // request a long receiver hold-off here
	localparam int PAUSE_AT       = 300;  // let the queue drain completely here
	localparam int RX_HOLD_CYCLES = 300;
	localparam int STALL_LIMIT    = 2000; // cycles with no transaction on either channel
	localparam int DRAIN_CYCLES   = 10;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	mrq_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	mrq_pkg::rsp_t rsp;

	bit quiet;          // set for the last part of the run: no gaps, no stalls
	bit hold_receiver;  // one-shot request for a long receiver hold-off
	int idle_cycles;

	ready_queue_scoreboard #(NUM_LEVELS, LEVEL_DEPTH, ID_BITS) sb;

	multilevel_ready_queue #(
		.NUM_LEVELS(NUM_LEVELS),
		.LEVEL_DEPTH(LEVEL_DEPTH),
		.ID_BITS(ID_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// Offer one request and hold it until the block takes it. Valid stays high on
	// return, so a request that follows at once keeps the channel busy.
	task automatic send_request(input logic op, input logic [7:0] id, input logic [2:0] level);
		mrq_pkg::req_t item;
		item.func = op;
		item.task_id = id;
		item.priority_req = level;
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	// Drop valid and wait until every predicted result has been delivered.
	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Monitor both channels on the edge that completes a transaction, and
	// watch for a hang: any transaction clears the idle count.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if (req_valid && req_ready)
				sb.apply_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$time, idle_cycles, sb.pending());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Receiver: ready in random stretches with random low bursts; honor one long
	// hold-off on request, counted here, so the sender backs up against the block.
	initial begin
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_receiver) begin
				rsp_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				hold_receiver = 1'b0;
			end
			rsp_ready <= 1'b1;
			if (quiet)
				@(posedge clk);
			else if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(20, 60)) @(posedge clk);
			else
				repeat ($urandom_range(1, 12)) @(posedge clk);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
	end

	// Sender: reset, directed corners, then biased random traffic, then the end check.
	initial begin
		int   lean;
		logic op;
		logic [2:0] level;
		logic [2:0] hot_a;
		logic [2:0] hot_b;

		sb = new();
		quiet = 1'b0;
		hold_receiver = 1'b0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue, extreme ids on the extreme levels, priority hand-over
		send_request(mrq_pkg::FUNC_DEQ, 8'h00, 3'd0);
		send_request(mrq_pkg::FUNC_ENQ, 8'hFF, 3'd7);
		send_request(mrq_pkg::FUNC_ENQ, 8'h00, 3'd0);
		send_request(mrq_pkg::FUNC_DEQ, 8'h00, 3'd0);
		send_request(mrq_pkg::FUNC_DEQ, 8'h00, 3'd7);
		send_request(mrq_pkg::FUNC_DEQ, 8'hFF, 3'd7);
		// Fill one level to the brim, then push one more: it must be dropped
		for (int i = 0; i < LEVEL_DEPTH; i++)
			send_request(mrq_pkg::FUNC_ENQ, 8'(i * 17 + 3), 3'd5);
		send_request(mrq_pkg::FUNC_ENQ, 8'hA5, 3'd5);

		// Random traffic in bursts of 20: each burst leans toward enqueues, toward
		// dequeues or neither, and favors two hot levels so they fill and empty.
		lean = 2;
		hot_a = 3'd0;
		hot_b = 3'd5;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 20 == 0) begin
				lean = $urandom_range(0, 2);
				hot_a = 3'($urandom_range(0, 7));
				hot_b = 3'($urandom_range(0, 7));
			end
			if (n == RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			if (n == HOLD_AT)
				hold_receiver = 1'b1;

			if (n == PAUSE_AT) begin
				drain_results();
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end

			case (lean)
				0: op = ($urandom_range(0, 9) < 8) ? mrq_pkg::FUNC_ENQ : mrq_pkg::FUNC_DEQ;
				1: op = ($urandom_range(0, 9) < 8) ? mrq_pkg::FUNC_DEQ : mrq_pkg::FUNC_ENQ;
				default: op = ($urandom_range(0, 1) == 0) ? mrq_pkg::FUNC_ENQ : mrq_pkg::FUNC_DEQ;
			endcase
			if ($urandom_range(0, 9) < 6)
				level = ($urandom_range(0, 1) == 0) ? hot_a : hot_b;
			else
				level = 3'($urandom_range(0, 7));
			send_request(op, 8'($urandom_range(0, 255)), level);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// File: multilevel_ready_queue.f
+incdir+sv
sv/mrq_pkg.sv
sv/multilevel_ready_queue.sv
verif/tb_multilevel_ready_queue.sv
